FILE: hw/rtl/clre_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clre_pkg: shared types and constants of the column level rank encoder
// Holds the field widths, the item kind codes, the stream word layout and
// the command group that runs from the controller to the datapath.
// ----------------------------------------------------------------------------
package clre_pkg;

  // Field widths of one input item and one result item.
  localparam int KIND_W  = 2;
  localparam int VAL_W   = 16;
  localparam int IDX_W   = 4;
  localparam int CODE_W  = 4;
  localparam int CNT_W   = 5;
  localparam int LEVEL_W = 16;

  // Stream word widths.
  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = 4;
  localparam int M_TDATA_W = 32;
  localparam int M_TUSER_W = 1;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_LEARN  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RECODE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the item and its compare vectors
    logic commit;   // update the table and load the result register
  } ctrl_cmd_t;

endpackage : clre_pkg
`default_nettype wire

FILE: hw/rtl/clre_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clre_ctrl: item sequencer of the column level rank encoder
// Two-state controller that accepts one item, lets the datapath apply it
// once the result register is free, and owns the result valid flag.
// ----------------------------------------------------------------------------
module clre_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output clre_pkg::ctrl_cmd_t     cmd
);
  import clre_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;
  logic   slot_free;

  // An item is taken only while no item is held for execution.
  assign in_ready    = (state == ST_IDLE);
  assign slot_free   = !out_valid || out_ready;
  assign cmd.capture = in_valid && in_ready;
  assign cmd.commit  = (state == ST_EXEC) && slot_free;

  // State and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule : clre_ctrl
`default_nettype wire

FILE: hw/rtl/clre_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clre_datapath: level table cell row and result register
// Each cell holds one sorted level and compares it with the incoming value
// in parallel. The less-than vector drives the sorted insert shift and the
// equal vector gives the rank of a known value.
// ----------------------------------------------------------------------------
module clre_datapath #(
  parameter int MAX_LEVELS = 16,
  parameter int VALUE_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire clre_pkg::ctrl_cmd_t                   cmd,
  input  wire logic [clre_pkg::KIND_W-1:0]           in_kind,
  input  wire logic signed [clre_pkg::VAL_W-1:0]     in_value,
  input  wire logic                                  in_missing,
  input  wire logic                                  in_first,
  input  wire logic [clre_pkg::IDX_W-1:0]            in_level_index,
  output logic [clre_pkg::CODE_W-1:0]                res_code,
  output logic                                       res_code_valid,
  output logic [clre_pkg::CNT_W-1:0]                 res_level_count,
  output logic signed [clre_pkg::LEVEL_W-1:0]        res_level_value,
  output logic                                       res_overflow
);
  import clre_pkg::*;

  localparam int CW = $clog2(MAX_LEVELS + 1);

  // Cell row and column state.
  logic signed [VALUE_BITS-1:0] tbl [MAX_LEVELS];
  logic [CW-1:0]                count;
  logic                         ovf;

  // Held item and its compare vectors.
  logic [KIND_W-1:0]            op_kind;
  logic signed [VALUE_BITS-1:0] op_value;
  logic                         op_missing;
  logic [IDX_W-1:0]             op_index;
  logic [MAX_LEVELS-1:0]        lt;
  logic [MAX_LEVELS-1:0]        eq;

  logic                         new_col;
  logic [CW-1:0]                cnt_eff;
  logic signed [VALUE_BITS-1:0] in_v;
  logic [MAX_LEVELS-1:0]        lt_w;
  logic [MAX_LEVELS-1:0]        eq_w;

  logic                         hit;
  logic                         learn_new;
  logic                         full;
  logic                         do_insert;
  logic [CW-1:0]                count_next;
  logic                         ovf_next;
  logic [CODE_W-1:0]            code_enc;
  logic signed [VALUE_BITS-1:0] rd_level;
  logic                         rd_ok;
  logic signed [VALUE_BITS-1:0] ins [MAX_LEVELS];
  logic [CODE_W-1:0]            code_next;
  logic                         valid_next;
  logic signed [LEVEL_W-1:0]    level_next;

  // A learn that opens a column sees an empty table.
  assign new_col = (in_kind == KIND_LEARN) && in_first;
  assign cnt_eff = new_col ? '0 : count;
  // The low VALUE_BITS bits of the value field form the two's complement level.
  assign in_v    = VALUE_BITS'($unsigned(in_value));

  // Parallel compare of the incoming value in every live cell.
  always_comb begin
    for (int i = 0; i < MAX_LEVELS; i++) begin
      lt_w[i] = (CW'(i) < cnt_eff) && (tbl[i] < in_v);
      eq_w[i] = (CW'(i) < cnt_eff) && (tbl[i] == in_v);
    end
  end

  // Learn outcome and next column state.
  assign hit        = |eq;
  assign learn_new  = (op_kind == KIND_LEARN) && !op_missing && !hit;
  assign full       = (count >= CW'(MAX_LEVELS));
  assign do_insert  = learn_new && !full;
  assign count_next = do_insert ? count + 1'b1 : count;
  assign ovf_next   = ovf || (learn_new && full);

  // Sorted insert: cells below the position keep, the position takes the
  // value, the cells above shift up by one.
  always_comb begin
    ins[0] = lt[0] ? tbl[0] : op_value;
    for (int i = 1; i < MAX_LEVELS; i++) begin
      if (lt[i]) begin
        ins[i] = tbl[i];
      end else if (lt[i-1]) begin
        ins[i] = op_value;
      end else begin
        ins[i] = tbl[i-1];
      end
    end
  end

  // Rank of a matching cell and the read-back selection.
  always_comb begin
    code_enc = '0;
    rd_level = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (eq[i]) begin
        code_enc = code_enc | CODE_W'(i);
      end
      if (32'(op_index) == 32'(i)) begin
        rd_level = tbl[i];
      end
    end
  end

  assign rd_ok = (32'(op_index) < 32'(count)) && (32'(op_index) < 32'(MAX_LEVELS));

  // Result fields by item kind.
  always_comb begin
    code_next  = '0;
    valid_next = 1'b0;
    level_next = '0;
    case (op_kind)
      KIND_RECODE: begin
        if (!op_missing && hit) begin
          code_next  = code_enc;
          valid_next = 1'b1;
        end
      end
      KIND_READ: begin
        if (rd_ok) begin
          code_next  = CODE_W'(op_index);
          valid_next = 1'b1;
          level_next = LEVEL_W'(rd_level);
        end
      end
      default: begin
        code_next = '0;
      end
    endcase
  end

  // Column state: cleared by a new column on capture, updated on commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      if (cmd.capture && new_col) begin
        count <= '0;
        ovf   <= 1'b0;
      end
      if (cmd.commit) begin
        count <= count_next;
        ovf   <= ovf_next;
      end
    end
  end

  // Held item and result register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_kind    <= in_kind;
      op_value   <= in_v;
      op_missing <= in_missing;
      op_index   <= in_level_index;
      lt         <= lt_w;
      eq         <= eq_w;
    end
    if (cmd.commit) begin
      res_code        <= code_next;
      res_code_valid  <= valid_next;
      res_level_count <= CNT_W'(count_next);
      res_level_value <= level_next;
      res_overflow    <= ovf_next;
    end
  end

  // Level cells.
  always_ff @(posedge clk) begin
    if (cmd.commit && do_insert) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        tbl[i] <= ins[i];
      end
    end
  end

  // The stored count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_LEVELS))
    else $error("level count beyond table depth");

  // Overflow is only ever raised by a full table and holds no fewer levels.
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> full)
    else $error("overflow set with room left in the table");

  // Stored levels are distinct, so at most one cell matches.
  a_eq_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(eq_w))
    else $error("more than one cell matches the value");

endmodule : clre_datapath
`default_nettype wire

FILE: hw/rtl/column_level_rank_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// column_level_rank_encoder: dense rank encoder for one category column
// Learns the sorted distinct levels of a column and recodes values to their
// 0-based rank. Every item returns exactly one result item.
// ----------------------------------------------------------------------------
// In the accept cycle the value is compared with every stored level at once
// in the cell row and the compare vectors are registered; once the result
// register is free, the sorted insert is applied and the result register is
// loaded. A new item is taken as soon as the previous one has reached the
// result register, not before. A learn item with first set opens a new
// column; the overflow flag stays set until then once a new level arrives
// at a full table.
module column_level_rank_encoder #(
  parameter int MAX_LEVELS = 16,
  parameter int VALUE_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // value [15:0], level_index [19:16], zero fill [23:20]
  input  wire logic [clre_pkg::S_TDATA_W-1:0]    s_tdata,
  // kind [1:0], missing [2], first [3]
  input  wire logic [clre_pkg::S_TUSER_W-1:0]    s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // code [3:0], level_count [8:4], level_value [24:9], overflow [25],
  // zero fill [31:26]
  output logic [clre_pkg::M_TDATA_W-1:0]         m_tdata,
  // code_valid [0]
  output logic [clre_pkg::M_TUSER_W-1:0]         m_tuser
);
  import clre_pkg::*;

  ctrl_cmd_t                 cmd;
  logic [CODE_W-1:0]         res_code;
  logic                      res_code_valid;
  logic [CNT_W-1:0]          res_level_count;
  logic signed [LEVEL_W-1:0] res_level_value;
  logic                      res_overflow;

  // Item sequencing and handshake.
  clre_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  // Level table and result register.
  clre_datapath #(
    .MAX_LEVELS (MAX_LEVELS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .in_kind         (s_tuser[1:0]),
    .in_value        (s_tdata[15:0]),
    .in_missing      (s_tuser[2]),
    .in_first        (s_tuser[3]),
    .in_level_index  (s_tdata[19:16]),
    .res_code        (res_code),
    .res_code_valid  (res_code_valid),
    .res_level_count (res_level_count),
    .res_level_value (res_level_value),
    .res_overflow    (res_overflow)
  );

  // Result word packing.
  assign m_tdata = {6'b0, res_overflow, res_level_value, res_level_count, res_code};
  assign m_tuser = res_code_valid;

endmodule : column_level_rank_encoder
`default_nettype wire
